// ----- sv/bfa_pkg.sv -----
package bfa_pkg;

    // Default geometry of the frame map
    localparam int FRAME_COUNT_DEF = 65536;
    localparam int PAGE_BYTES_DEF  = 4096;

    // The map is stored as words of 64 frame bits
    localparam int WORD_BITS  = 64;
    localparam int WORD_SHIFT = 6;

    // Port widths fixed by the request and result formats
    localparam int BASE_W   = 64;
    localparam int ADDR_W   = 28;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 17;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        KIND_RELEASE = 2'd0,
        KIND_RESERVE = 2'd1,
        KIND_ALLOC   = 2'd2,
        KIND_FREE    = 2'd3
    } kind_t;

    localparam logic [STATUS_W-1:0] STAT_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NO_MEMORY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_IGNORED   = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic clear_write;
        logic load;
        logic calc_sum;
        logic calc_bounds;
        logic prep;
        logic read;
        logic modify;
        logic accumulate;
        logic advance;
        logic finish;
    } bfa_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic clear_last;
        logic empty;
        logic last_word;
        logic found;
        logic is_alloc;
    } bfa_stat_t;

endpackage

// ----- sv/bfa_datapath.sv -----
module bfa_datapath
    import bfa_pkg::*;
#(
    parameter int FRAME_COUNT = FRAME_COUNT_DEF,
    parameter int PAGE_BYTES  = PAGE_BYTES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  bfa_cmd_t            cmd,
    output bfa_stat_t           stat,
    input  logic [1:0]          s_kind,
    input  logic [BASE_W-1:0]   s_range_base,
    input  logic [BASE_W-1:0]   s_range_length,
    output logic [ADDR_W-1:0]   m_frame_address,
    output logic [STATUS_W-1:0] m_status,
    output logic [COUNT_W-1:0]  m_total_count,
    output logic [COUNT_W-1:0]  m_used_count
);

    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int MAP_WORDS  = (FRAME_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int WADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int FIDX_W     = $clog2(FRAME_COUNT + 1);
    localparam int LIDX_W     = WADDR_W + WORD_SHIFT;
    localparam int SUM_W      = BASE_W + 1;
    localparam int FRAMES_W   = SUM_W - PAGE_SHIFT + 1;
    localparam int AFULL_W    = ADDR_W + LIDX_W;
    localparam int POP_W      = WORD_SHIFT + 1;

    logic [WORD_BITS-1:0] map_mem [MAP_WORDS];

    kind_t                kind_reg;
    logic [BASE_W-1:0]    base_reg;
    logic [BASE_W-1:0]    length_reg;
    logic [SUM_W-1:0]     sum_reg;
    logic [FIDX_W-1:0]    s_reg;
    logic [FIDX_W-1:0]    e_reg;
    logic [FIDX_W-1:0]    elast_reg;
    logic                 empty_reg;
    logic [WADDR_W-1:0]   w_reg;
    logic [WORD_BITS-1:0] rdata_reg;
    logic [WORD_BITS-1:0] changed_reg;
    logic [COUNT_W-1:0]   total_reg;
    logic [COUNT_W-1:0]   used_reg;
    logic [ADDR_W-1:0]    addr_out_reg;
    logic [STATUS_W-1:0]  status_out_reg;
    logic [COUNT_W-1:0]   total_out_reg;
    logic [COUNT_W-1:0]   used_out_reg;

    logic [FRAMES_W-1:0]   base_floor;
    logic                  base_frac;
    logic [FRAMES_W-1:0]   sum_floor;
    logic                  sum_frac;
    logic [FRAMES_W-1:0]   lo_frames;
    logic [FRAMES_W-1:0]   hi_frames;
    logic [WORD_SHIFT-1:0] lo_off;
    logic [WORD_SHIFT-1:0] hi_off;
    logic [WORD_BITS-1:0]  mask;
    logic [WORD_BITS-1:0]  cand;
    logic [WORD_BITS-1:0]  changed_next;
    logic [WORD_BITS-1:0]  new_word;
    logic [3:0]            byte_cnt [WORD_BITS/8];
    logic [POP_W-1:0]      pop;
    logic [COUNT_W:0]      total_sum;
    logic [COUNT_W:0]      used_sum;
    logic [WORD_SHIFT-1:0] bit_pos;
    logic [AFULL_W-1:0]    addr_full;
    logic                  found;

    function automatic logic [FIDX_W-1:0] clamp_frames(input logic [FRAMES_W-1:0] v);
        logic [FIDX_W-1:0] r;
        if (v > FRAMES_W'(FRAME_COUNT)) begin
            r = FIDX_W'(FRAME_COUNT);
        end else begin
            r = v[FIDX_W-1:0];
        end
        return r;
    endfunction

    // Frame bounds of the request; pages are a power of two so rounding is a mask
    always_comb begin
        base_floor = FRAMES_W'(base_reg >> PAGE_SHIFT);
        base_frac  = |base_reg[PAGE_SHIFT-1:0];
        sum_floor  = FRAMES_W'(sum_reg >> PAGE_SHIFT);
        sum_frac   = |sum_reg[PAGE_SHIFT-1:0];
        case (kind_reg)
            KIND_RELEASE: begin
                lo_frames = base_floor + FRAMES_W'(base_frac);
                hi_frames = sum_floor;
            end
            KIND_RESERVE: begin
                lo_frames = base_floor;
                hi_frames = sum_floor + FRAMES_W'(sum_frac);
            end
            KIND_ALLOC: begin
                lo_frames = '0;
                hi_frames = FRAMES_W'(FRAME_COUNT);
            end
            default: begin
                lo_frames = base_floor;
                hi_frames = base_floor + FRAMES_W'(1);
            end
        endcase
    end

    // Bits of the current word that lie inside [s, e)
    always_comb begin
        lo_off = (w_reg == s_reg[WORD_SHIFT +: WADDR_W]) ? s_reg[WORD_SHIFT-1:0] : '0;
        hi_off = (w_reg == elast_reg[WORD_SHIFT +: WADDR_W]) ?
                 elast_reg[WORD_SHIFT-1:0] : '1;
        for (int b = 0; b < WORD_BITS; b++) begin
            mask[b] = (WORD_SHIFT'(b) >= lo_off) && (WORD_SHIFT'(b) <= hi_off);
        end
    end

    always_comb begin
        cand = mask & ~rdata_reg;
        case (kind_reg)
            KIND_RELEASE: begin
                changed_next = mask & rdata_reg;
                new_word     = rdata_reg & ~changed_next;
            end
            KIND_RESERVE: begin
                changed_next = cand;
                new_word     = rdata_reg | changed_next;
            end
            KIND_ALLOC: begin
                changed_next = cand & (~cand + WORD_BITS'(1));
                new_word     = rdata_reg | changed_next;
            end
            default: begin
                changed_next = mask & rdata_reg;
                new_word     = rdata_reg & ~changed_next;
            end
        endcase
    end

    // Population count of the changed bits, byte by byte
    always_comb begin
        pop = '0;
        for (int i = 0; i < WORD_BITS / 8; i++) begin
            byte_cnt[i] = '0;
            for (int j = 0; j < 8; j++) begin
                byte_cnt[i] = byte_cnt[i] + 4'(changed_reg[8*i + j]);
            end
            pop = pop + POP_W'(byte_cnt[i]);
        end
        total_sum = {1'b0, total_reg} + (COUNT_W+1)'(pop);
        used_sum  = {1'b0, used_reg} + (COUNT_W+1)'(pop);
    end

    always_comb begin
        found   = |changed_reg;
        bit_pos = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            if (changed_reg[b]) begin
                bit_pos = bit_pos | WORD_SHIFT'(b);
            end
        end
        addr_full = AFULL_W'({w_reg, bit_pos}) << PAGE_SHIFT;
    end

    // Map memory: one write port, one registered read port, both at w_reg
    always_ff @(posedge aclk) begin
        if (cmd.clear_write) begin
            map_mem[w_reg] <= '1;
        end else if (cmd.modify) begin
            map_mem[w_reg] <= new_word;
        end
        if (cmd.read) begin
            rdata_reg <= map_mem[w_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_reg     <= '0;
            total_reg <= '0;
            used_reg  <= '0;
        end else begin
            if (cmd.clear_write || cmd.advance) begin
                w_reg <= w_reg + WADDR_W'(1);
            end else if (cmd.prep) begin
                w_reg <= s_reg[WORD_SHIFT +: WADDR_W];
            end
            if (cmd.accumulate) begin
                case (kind_reg)
                    KIND_RELEASE: begin
                        total_reg <= (total_sum > {1'b0, COUNT_MAX}) ?
                                     COUNT_MAX : total_sum[COUNT_W-1:0];
                    end
                    KIND_FREE: begin
                        if (found && (used_reg != '0)) begin
                            used_reg <= used_reg - COUNT_W'(1);
                        end
                    end
                    default: begin
                        used_reg <= (used_sum > {1'b0, COUNT_MAX}) ?
                                    COUNT_MAX : used_sum[COUNT_W-1:0];
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg   <= kind_t'(s_kind);
            base_reg   <= s_range_base;
            length_reg <= s_range_length;
        end
        if (cmd.calc_sum) begin
            sum_reg <= {1'b0, base_reg} + {1'b0, length_reg};
        end
        if (cmd.calc_bounds) begin
            s_reg <= clamp_frames(lo_frames);
            e_reg <= clamp_frames(hi_frames);
        end
        if (cmd.prep) begin
            elast_reg   <= e_reg - FIDX_W'(1);
            empty_reg   <= (s_reg >= e_reg);
            changed_reg <= '0;
        end else if (cmd.modify) begin
            changed_reg <= changed_next;
        end
        if (cmd.finish) begin
            total_out_reg <= total_reg;
            used_out_reg  <= used_reg;
            if (kind_reg == KIND_ALLOC) begin
                addr_out_reg   <= found ? addr_full[ADDR_W-1:0] : '0;
                status_out_reg <= found ? STAT_DONE : STAT_NO_MEMORY;
            end else if (kind_reg == KIND_FREE) begin
                addr_out_reg   <= '0;
                status_out_reg <= found ? STAT_DONE : STAT_IGNORED;
            end else begin
                addr_out_reg   <= '0;
                status_out_reg <= STAT_DONE;
            end
        end
    end

    assign stat.clear_last = (w_reg == WADDR_W'(MAP_WORDS - 1));
    assign stat.empty      = empty_reg;
    assign stat.last_word  = (w_reg == elast_reg[WORD_SHIFT +: WADDR_W]);
    assign stat.found      = found;
    assign stat.is_alloc   = (kind_reg == KIND_ALLOC);

    assign m_frame_address = addr_out_reg;
    assign m_status        = status_out_reg;
    assign m_total_count   = total_out_reg;
    assign m_used_count    = used_out_reg;

    // Allocate and free touch at most one frame per word.
    a_single_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.modify && (kind_reg == KIND_ALLOC || kind_reg == KIND_FREE)
        |=> $onehot0(changed_reg))
        else $error("allocate or free changed more than one frame");

    // Only a free can lower the used count.
    a_used_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accumulate && kind_reg != KIND_FREE |=> used_reg >= $past(used_reg))
        else $error("used count fell outside a free");

    // The available total only moves when a word is accounted.
    a_total_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        !cmd.accumulate |=> total_reg == $past(total_reg))
        else $error("available total changed without accounting");

endmodule

// ----- sv/bfa_ctrl.sv -----
module bfa_ctrl
    import bfa_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    input  bfa_stat_t stat,
    output bfa_cmd_t  cmd
);

    typedef enum logic [3:0] {
        CLEAR,
        IDLE,
        SUM,
        BOUNDS,
        PREP,
        READ,
        MODIFY,
        ACC,
        RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        unique case (state_reg)
            CLEAR: begin
                cmd.clear_write = 1'b1;
                if (stat.clear_last) begin
                    state_next = IDLE;
                end
            end
            IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = SUM;
                end
            end
            SUM: begin
                cmd.calc_sum = 1'b1;
                state_next   = BOUNDS;
            end
            BOUNDS: begin
                cmd.calc_bounds = 1'b1;
                state_next      = PREP;
            end
            PREP: begin
                cmd.prep   = 1'b1;
                state_next = READ;
            end
            READ: begin
                if (stat.empty) begin
                    state_next = RESULT;
                end else begin
                    cmd.read   = 1'b1;
                    state_next = MODIFY;
                end
            end
            MODIFY: begin
                cmd.modify = 1'b1;
                state_next = ACC;
            end
            ACC: begin
                cmd.accumulate = 1'b1;
                if ((stat.is_alloc && stat.found) || stat.last_word) begin
                    state_next = RESULT;
                end else begin
                    cmd.advance = 1'b1;
                    state_next  = READ;
                end
            end
            RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.finish   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = IDLE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == IDLE);
    assign m_valid = m_valid_reg;

    // A finished result waits while the previous one is still held.
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == RESULT && m_valid_reg && !m_ready |=> state_reg == RESULT)
        else $error("result overwritten before it was taken");

    // A new result only appears out of the result state.
    a_valid_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == RESULT)
        else $error("result valid raised outside the result state");

    // A presented result stays presented until the receiver takes it.
    a_valid_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |=> m_valid_reg)
        else $error("result valid dropped before it was taken");

endmodule

// ----- sv/bitmap_frame_allocator_unit.sv -----
// First-fit bitmap page-frame allocator.
// Requests arrive on the s_ channel (s_valid/s_ready) and each carries a kind:
// release a byte range, reserve a byte range, allocate one frame, or free one
// frame. Every request yields exactly one result on the m_ channel
// (m_valid/m_ready) holding the allocated address, a status code and both
// frame counters as they stand after the request.
// The controller steps from acceptance through its sum, bounds and prep
// states, then visits each 64-frame map word the request needs: an empty
// range or a free beyond the map visits none, a free visits one, an
// allocate stops at the first word holding a free frame (at most
// FRAME_COUNT/64 words). Each word takes a read, a modify-and-write and an
// accounting state, before the result state loads the output register.
// A new request is accepted in the cycle after the previous result is loaded.
// After reset the block sweeps the map setting every frame reserved, one word
// per cycle; s_ready stays low until the sweep ends. Both counters reset to
// zero.
// The result sits in an output register: a stalled receiver does not stop the
// next request being accepted and worked on, but that request's result waits
// until the held one has been taken.

module bitmap_frame_allocator_unit
    import bfa_pkg::*;
#(
    parameter int FRAME_COUNT = FRAME_COUNT_DEF,
    parameter int PAGE_BYTES  = PAGE_BYTES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_kind,
    input  logic [BASE_W-1:0]   s_range_base,
    input  logic [BASE_W-1:0]   s_range_length,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [ADDR_W-1:0]   m_frame_address,
    output logic [STATUS_W-1:0] m_status,
    output logic [COUNT_W-1:0]  m_total_count,
    output logic [COUNT_W-1:0]  m_used_count
);

    // The controller sequences each request; the datapath owns the map,
    // the counters and the result register.
    bfa_cmd_t  cmd;
    bfa_stat_t stat;

    bfa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    bfa_datapath #(
        .FRAME_COUNT (FRAME_COUNT),
        .PAGE_BYTES  (PAGE_BYTES)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .s_kind          (s_kind),
        .s_range_base    (s_range_base),
        .s_range_length  (s_range_length),
        .m_frame_address (m_frame_address),
        .m_status        (m_status),
        .m_total_count   (m_total_count),
        .m_used_count    (m_used_count)
    );

endmodule
